// ===== rtl/core/sdtw_pkg.sv =====
// Shared types, codes and constants of the short-descriptor table walker.
`default_nettype none
package sdtw_pkg;

	// Opcodes of an input beat.
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_DATA      = 1'b1;

	// Kinds of a result beat.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_ACCESS = 1'd1;

	localparam int unsigned TABLE_BASE_W = 18;
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned MODE_W       = 5;
	localparam int unsigned DOM_W        = 4;
	localparam int unsigned FAULT_W      = 3;

	localparam logic [MODE_W-1:0] MODE_USER = 5'h10;

	// Fault codes.
	localparam logic [FAULT_W-1:0] FLT_NONE       = 3'd0;
	localparam logic [FAULT_W-1:0] FLT_SECT_TRANS = 3'd1;
	localparam logic [FAULT_W-1:0] FLT_PAGE_TRANS = 3'd2;
	localparam logic [FAULT_W-1:0] FLT_SECT_DOM   = 3'd3;
	localparam logic [FAULT_W-1:0] FLT_PAGE_DOM   = 3'd4;
	localparam logic [FAULT_W-1:0] FLT_SECT_PERM  = 3'd5;
	localparam logic [FAULT_W-1:0] FLT_PAGE_PERM  = 3'd6;
	localparam logic [FAULT_W-1:0] FLT_RESERVED   = 3'd7;

	// Descriptor type codes.
	localparam logic [1:0] L1_FAULT    = 2'd0;
	localparam logic [1:0] L1_COARSE   = 2'd1;
	localparam logic [1:0] L1_SECTION  = 2'd2;
	localparam logic [1:0] L1_RESERVED = 2'd3;
	localparam logic [1:0] L2_FAULT    = 2'd0;
	localparam logic [1:0] L2_LARGE    = 2'd1;

	// Domain access field values.
	localparam logic [1:0] DACR_CLIENT  = 2'd1;
	localparam logic [1:0] DACR_MANAGER = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_L1   = 2'd1,
		PH_L2   = 2'd2
	} phase_t;

	// Inputs of the domain and permission check.
	typedef struct packed {
		logic [DOM_W-1:0] dom;
		logic             apx;
		logic [1:0]       ap;
		logic             user;
		logic             wr;
		logic             page;
	} perm_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdtw_if.sv =====
// Valid/ready channel interfaces of the table walker: requests, results, configuration.
`default_nettype none
interface sdtw_req_if import sdtw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [ADDR_W-1:0] virt_addr;
	logic [MODE_W-1:0] cpu_mode;
	logic              is_write;
	logic [DATA_W-1:0] read_data;
	modport source (output valid, opcode, virt_addr, cpu_mode, is_write, read_data,
		input ready);
	modport sink (input valid, opcode, virt_addr, cpu_mode, is_write, read_data,
		output ready);
endinterface

interface sdtw_rsp_if import sdtw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [ADDR_W-1:0]  read_addr;
	logic [ADDR_W-1:0]  phys_addr;
	logic [FAULT_W-1:0] fault;
	logic [DOM_W-1:0]   fault_domain;
	logic               cacheable;
	modport source (output valid, kind, read_addr, phys_addr, fault, fault_domain,
		cacheable, input ready);
	modport sink (input valid, kind, read_addr, phys_addr, fault, fault_domain,
		cacheable, output ready);
endinterface

interface sdtw_cfg_if import sdtw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sdtw_perm.sv =====
// Domain access and AP/APX permission check for a finished walk.
`default_nettype none
module sdtw_perm import sdtw_pkg::*; (
	input  wire logic [DATA_W-1:0]  domain_access,
	input  wire perm_req_t          req,
	output logic [FAULT_W-1:0]      fault
);

	logic [1:0] acc;
	logic       ok;

	assign acc = domain_access[{req.dom, 1'b0} +: 2];

	always_comb begin
		if (!req.apx) begin
			case (req.ap)
				2'd0:    ok = 1'b0;
				2'd1:    ok = !req.user;
				2'd2:    ok = !(req.wr && req.user);
				default: ok = 1'b1;
			endcase
		end else begin
			case (req.ap)
				2'd0:    ok = 1'b0;
				2'd1:    ok = !(req.user || req.wr);
				default: ok = !req.wr;
			endcase
		end
	end

	always_comb begin
		if (acc == DACR_MANAGER)
			fault = FLT_NONE;
		else if (acc != DACR_CLIENT)
			fault = req.page ? FLT_PAGE_DOM : FLT_SECT_DOM;
		else if (ok)
			fault = FLT_NONE;
		else
			fault = req.page ? FLT_PAGE_PERM : FLT_SECT_PERM;
	end

endmodule
`default_nettype wire

// ===== rtl/core/short_descriptor_table_walk_top.sv =====
// Top level of the two-level short-descriptor page table walker.
`default_nettype none
// The walker takes one beat per clock cycle on req and answers each beat that
// produces a result with a single beat on rsp in the next cycle. A translate beat
// (opcode 0) seen while idle latches the address, mode and write flag and returns
// a level-1 descriptor read request; the descriptor word comes back as an opcode 1
// beat. A section or fault descriptor finishes the walk, a coarse descriptor
// yields a level-2 read request and the level-2 word then finishes it. Translate
// beats arriving mid-walk and data beats arriving while idle are swallowed with
// no result. Each beat is decoded by shallow logic from the walk state and
// written straight into the output register, so the sustained rate is one beat
// per cycle; req stalls only while the output register is full and rsp is not
// taking it. Memory latency lies entirely outside the block. The cfg channel is
// always ready; table_base and domain_access should be written only while no
// walk is in flight.
module short_descriptor_table_walk_top import sdtw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdtw_req_if.sink   req,
	sdtw_rsp_if.source rsp,
	sdtw_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [TABLE_BASE_W-1:0] table_base_q;
	logic [DATA_W-1:0]       domain_access_q;

	// Walk state: the phase, the request that started the walk and the level-1 domain.
	phase_t            phase_q, phase_nxt;
	logic [ADDR_W-1:0] vaddr_q;
	logic              user_q;
	logic              write_q;
	logic [DOM_W-1:0]  l1_dom_q;

	// Output register.
	logic               rsp_valid_q;
	logic               kind_q;
	logic [ADDR_W-1:0]  read_addr_q;
	logic [ADDR_W-1:0]  phys_addr_q;
	logic [FAULT_W-1:0] fault_q;
	logic [DOM_W-1:0]   dom_q;
	logic               c_q;

	// Result of the beat being decoded this cycle.
	logic               res_valid;
	logic               res_kind;
	logic [ADDR_W-1:0]  res_read_addr;
	logic [ADDR_W-1:0]  res_phys_addr;
	logic [FAULT_W-1:0] res_fault;
	logic [DOM_W-1:0]   res_dom;
	logic               res_c;

	logic              accept;
	logic              latch_req;
	logic [1:0]        d_type;
	logic [DATA_W-1:0] d;
	perm_req_t         perm_req;
	logic [FAULT_W-1:0] perm_fault;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q    <= '0;
			domain_access_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TABLE_BASE:    table_base_q    <= cfg.data[TABLE_BASE_W-1:0];
				REG_DOMAIN_ACCESS: domain_access_q <= cfg.data;
				default:           ;
			endcase
		end
	end

	// A new beat goes in whenever the output register is empty or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign d         = req.read_data;
	assign d_type    = d[1:0];

	// Only a translate beat in the idle phase starts a walk.
	assign latch_req = accept && (req.opcode == OP_TRANSLATE) && (phase_q == PH_IDLE);

	// The domain check uses the level-1 domain of the word itself for a section and
	// the stored one for a page; the AP bits sit in different places at each level.
	always_comb begin
		perm_req.user = user_q;
		perm_req.wr   = write_q;
		if (phase_q == PH_L2) begin
			perm_req.dom  = l1_dom_q;
			perm_req.apx  = d[9];
			perm_req.ap   = d[5:4];
			perm_req.page = 1'b1;
		end else begin
			perm_req.dom  = d[8:5];
			perm_req.apx  = d[15];
			perm_req.ap   = d[11:10];
			perm_req.page = 1'b0;
		end
	end

	sdtw_perm u_perm (
		.domain_access (domain_access_q),
		.req           (perm_req),
		.fault         (perm_fault)
	);

	// Next phase.
	always_comb begin
		phase_nxt = phase_q;
		if (accept) begin
			case (phase_q)
				PH_IDLE: begin
					if (req.opcode == OP_TRANSLATE)
						phase_nxt = PH_L1;
				end
				PH_L1: begin
					if (req.opcode == OP_DATA)
						phase_nxt = (d_type == L1_COARSE) ? PH_L2 : PH_IDLE;
				end
				PH_L2: begin
					if (req.opcode == OP_DATA)
						phase_nxt = PH_IDLE;
				end
				default: phase_nxt = PH_IDLE;
			endcase
		end
	end

	// Result of the current beat.
	always_comb begin
		res_valid     = 1'b0;
		res_kind      = KIND_READ;
		res_read_addr = '0;
		res_phys_addr = '0;
		res_fault     = FLT_NONE;
		res_dom       = '0;
		res_c         = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (req.opcode == OP_TRANSLATE) begin
					res_valid     = 1'b1;
					res_read_addr = {table_base_q, req.virt_addr[31:20], 2'b00};
				end
			end
			PH_L1: begin
				if (req.opcode == OP_DATA) begin
					res_valid = 1'b1;
					if (d_type == L1_COARSE) begin
						res_read_addr = {d[31:10], vaddr_q[19:12], 2'b00};
					end else begin
						res_kind = KIND_DONE;
						res_dom  = d[8:5];
						case (d_type)
							L1_FAULT:    res_fault = FLT_SECT_TRANS;
							L1_RESERVED: res_fault = FLT_RESERVED;
							default: begin
								res_fault = perm_fault;
								res_c     = d[3];
								if (perm_fault == FLT_NONE)
									res_phys_addr = {d[31:20], vaddr_q[19:0]};
							end
						endcase
					end
				end
			end
			PH_L2: begin
				if (req.opcode == OP_DATA) begin
					res_valid = 1'b1;
					res_kind  = KIND_DONE;
					res_dom   = l1_dom_q;
					if (d_type == L2_FAULT) begin
						res_fault = FLT_PAGE_TRANS;
					end else begin
						res_fault = perm_fault;
						res_c     = d[3];
						if (perm_fault == FLT_NONE) begin
							if (d_type == L2_LARGE)
								res_phys_addr = {d[31:16], vaddr_q[15:0]};
							else
								res_phys_addr = {d[31:12], vaddr_q[11:0]};
						end
					end
				end
			end
			default: begin
				// An unused phase code gives the same result as idle, but the next phase is idle.
				if (req.opcode == OP_TRANSLATE) begin
					res_valid     = 1'b1;
					res_read_addr = {table_base_q, req.virt_addr[31:20], 2'b00};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			vaddr_q  <= '0;
			user_q   <= 1'b0;
			write_q  <= 1'b0;
			l1_dom_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			if (latch_req) begin
				vaddr_q <= req.virt_addr;
				user_q  <= (req.cpu_mode == MODE_USER);
				write_q <= req.is_write;
			end
			if (accept && req.opcode == OP_DATA && phase_q == PH_L1)
				l1_dom_q <= d[8:5];
		end
	end

	// Output register: loaded by a beat that produces a result, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= res_valid;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			kind_q      <= res_kind;
			read_addr_q <= res_read_addr;
			phys_addr_q <= res_phys_addr;
			fault_q     <= res_fault;
			dom_q       <= res_dom;
			c_q         <= res_c;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = kind_q;
	assign rsp.read_addr    = read_addr_q;
	assign rsp.phys_addr    = phys_addr_q;
	assign rsp.fault        = fault_q;
	assign rsp.fault_domain = dom_q;
	assign rsp.cacheable    = c_q;

endmodule
`default_nettype wire
